// ===== rtl/core/mbpq_pkg.sv =====
// shared types and constants for the bucket priority queue
`timescale 1ns / 1ps
package mbpq_pkg;
    localparam int NUM_LEVELS   = 256;
    localparam int NUM_ELEMENTS = 1024;
    localparam int EW = $clog2(NUM_ELEMENTS);
    localparam int LW = $clog2(NUM_LEVELS);

    // null link and the not-queued level mark
    localparam logic [EW:0] LINK_NULL  = (EW+1)'(NUM_ELEMENTS);
    localparam logic [EW:0] NOT_QUEUED = (EW+1)'(NUM_LEVELS);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_POP    = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_ABSENT    = 2'd3;

    localparam logic CFG_ORDER_MODE = 1'b0;
    localparam logic CFG_TIE_POLICY = 1'b1;

    // memory select for the datapath commands
    localparam logic [2:0] MS_NONE  = 3'd0;
    localparam logic [2:0] MS_HEAD  = 3'd1;
    localparam logic [2:0] MS_TAIL  = 3'd2;
    localparam logic [2:0] MS_NEXT  = 3'd3;
    localparam logic [2:0] MS_PREV  = 3'd4;
    localparam logic [2:0] MS_LEVEL = 3'd5;
    localparam logic [2:0] MS_CLEAR = 3'd6;
endpackage

// ===== rtl/core/mbpq_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module mbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/core/mbpq_ctrl.sv =====
// sequencer for the bucket priority queue
`timescale 1ns / 1ps
module mbpq_ctrl
    import mbpq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_op,
    input  logic [7:0]    i_priority_req,
    input  logic [9:0]    i_element,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [9:0]    o_popped_element,
    output logic          o_present,
    output logic          o_is_empty,
    output logic [10:0]   o_count,
    output logic [1:0]    o_status,
    // datapath command
    output logic [2:0]    o_mem_sel,
    output logic          o_mem_we,
    output logic [EW-1:0] o_mem_addr,
    output logic [EW:0]   o_mem_wdata,
    input  logic [EW:0]   i_mem_rdata
);
    localparam logic [4:0] S_CLR   = 5'd0,  S_IDLE = 5'd1,  S_RLV  = 5'd2,
                           S_WLV   = 5'd3,  S_DEC  = 5'd4,  S_AH   = 5'd5,
                           S_AW1   = 5'd6,  S_AW2  = 5'd7,  S_AW3  = 5'd8,
                           S_AW4   = 5'd9,  S_UP   = 5'd10, S_UN   = 5'd11,
                           S_UW1   = 5'd12, S_UW2  = 5'd13, S_UW3  = 5'd14,
                           S_PH    = 5'd15, S_PW   = 5'd16, S_DONE = 5'd17,
                           S_OUT   = 5'd18, S_RD   = 5'd19;

    logic [4:0]    r_state, n_state;
    logic [EW-1:0] r_clr;
    logic          r_order, r_tie;
    logic [LW-1:0] r_cursor, r_scan;
    logic [10:0]   r_cnt;
    logic [1:0]    r_op;
    logic [LW-1:0] r_pr;
    logic [EW-1:0] r_e;
    logic [EW:0]   r_lv, r_p, r_n, r_x;
    logic [1:0]    r_status;
    logic [EW-1:0] r_popped;
    logic          r_orig_valid;
    logic [EW-1:0] r_orig_e;
    logic          w_in_range;

    assign w_in_range = ({1'b0, i_element} < 11'(NUM_ELEMENTS));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_popped_element = 10'(r_popped);
    // level of the input element is read in the done state and held while the word waits
    assign o_present = r_orig_valid && (i_mem_rdata != NOT_QUEUED);
    assign o_count = r_cnt;
    assign o_is_empty = (r_cnt == 11'd0);
    assign o_status = r_status;

    // datapath command decode
    always_comb begin
        o_mem_sel = MS_NONE;
        o_mem_we = 1'b0;
        o_mem_addr = '0;
        o_mem_wdata = '0;
        case (r_state)
            S_CLR: begin
                o_mem_we = 1'b1;
                o_mem_sel = MS_CLEAR;
                o_mem_addr = r_clr;
            end
            S_RLV: begin o_mem_sel = MS_LEVEL; o_mem_addr = r_e; end
            S_AH: begin
                o_mem_sel = r_tie ? MS_HEAD : MS_TAIL;
                o_mem_addr = EW'(r_pr);
            end
            S_AW1: begin
                o_mem_sel = MS_PREV; o_mem_we = 1'b1; o_mem_addr = r_e;
                o_mem_wdata = r_tie ? LINK_NULL : i_mem_rdata;
            end
            S_AW2: begin
                o_mem_sel = MS_NEXT; o_mem_we = 1'b1; o_mem_addr = r_e;
                o_mem_wdata = r_tie ? r_x : LINK_NULL;
            end
            S_AW3: begin
                o_mem_we = 1'b1;
                o_mem_wdata = (EW+1)'(r_e);
                if (r_x == LINK_NULL) begin
                    o_mem_sel = r_tie ? MS_TAIL : MS_HEAD;
                    o_mem_addr = EW'(r_pr);
                end else begin
                    o_mem_sel = r_tie ? MS_PREV : MS_NEXT;
                    o_mem_addr = r_x[EW-1:0];
                end
            end
            S_AW4: begin
                o_mem_sel = r_tie ? MS_HEAD : MS_TAIL; o_mem_we = 1'b1;
                o_mem_addr = EW'(r_pr); o_mem_wdata = (EW+1)'(r_e);
            end
            S_WLV: begin
                o_mem_sel = MS_LEVEL; o_mem_we = 1'b1; o_mem_addr = r_e;
                o_mem_wdata = (r_op == OP_ADD) ? (EW+1)'(r_pr) : NOT_QUEUED;
            end
            S_UP: begin o_mem_sel = MS_PREV; o_mem_addr = r_e; end
            S_UN: begin o_mem_sel = MS_NEXT; o_mem_addr = r_e; end
            S_UW1: begin
                o_mem_we = 1'b1; o_mem_wdata = i_mem_rdata;
                if (r_p == LINK_NULL) begin
                    o_mem_sel = MS_HEAD; o_mem_addr = r_lv[EW-1:0];
                end else begin
                    o_mem_sel = MS_NEXT; o_mem_addr = r_p[EW-1:0];
                end
            end
            S_UW2: begin
                o_mem_we = 1'b1; o_mem_wdata = r_p;
                if (r_n == LINK_NULL) begin
                    o_mem_sel = MS_TAIL; o_mem_addr = r_lv[EW-1:0];
                end else begin
                    o_mem_sel = MS_PREV; o_mem_addr = r_n[EW-1:0];
                end
            end
            S_PH: begin o_mem_sel = MS_HEAD; o_mem_addr = EW'(r_scan); end
            S_DONE, S_OUT: begin o_mem_sel = MS_LEVEL; o_mem_addr = r_orig_e; end
            default: ;
        endcase
    end

    // state sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: if (r_clr == EW'(NUM_ELEMENTS - 1)) n_state = S_IDLE;
            S_IDLE: if (i_valid) begin
                if (i_op == OP_POP) n_state = S_PH;
                else n_state = S_RLV;
            end
            S_RLV: n_state = S_RD;
            S_RD: begin
                if (r_op == OP_QUERY || !r_orig_valid) n_state = S_DONE;
                else if (r_op == OP_ADD) begin
                    n_state = (i_mem_rdata != NOT_QUEUED) ? S_DONE : S_AH;
                end else n_state = (i_mem_rdata == NOT_QUEUED) ? S_DONE : S_UP;
            end
            S_AH: n_state = S_AW1;
            S_AW1: n_state = S_AW2;
            S_AW2: n_state = S_AW3;
            S_AW3: n_state = S_AW4;
            S_AW4: n_state = S_WLV;
            S_UP: n_state = S_UN;
            S_UN: n_state = S_UW1;
            S_UW1: n_state = S_UW2;
            S_UW2: n_state = S_WLV;
            S_WLV: n_state = S_DEC;
            S_DEC: n_state = S_DONE;
            S_PH: n_state = S_PW;
            S_PW: begin
                if (i_mem_rdata != LINK_NULL) n_state = S_UP;
                else if ((!r_order && r_scan == LW'(NUM_LEVELS - 1)) ||
                         (r_order && r_scan == '0)) n_state = S_DONE;
                else n_state = S_PH;
            end
            S_DONE: n_state = S_OUT;
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_order <= 1'b0;
            r_tie <= 1'b0;
            r_cursor <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + EW'(1);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ORDER_MODE) begin
                    r_order <= i_cfg_data;
                    r_cursor <= i_cfg_data ? LW'(NUM_LEVELS - 1) : '0;
                end else begin
                    r_tie <= i_cfg_data;
                end
            end
            if (r_state == S_PW && i_mem_rdata != LINK_NULL) r_cursor <= r_scan;
            if (r_state == S_DEC) begin
                r_cnt <= (r_op == OP_ADD) ? r_cnt + 11'd1 : r_cnt - 11'd1;
            end
        end
    end

    // datapath-side working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op <= i_op;
                r_pr <= i_priority_req;
                r_e <= i_element;
                r_orig_e <= i_element;
                r_orig_valid <= w_in_range;
                r_scan <= r_cursor;
                r_status <= ST_OK;
                r_popped <= '0;
            end
            S_RD: begin
                r_lv <= i_mem_rdata;
                if (!r_orig_valid && r_op != OP_QUERY) r_status <= ST_ABSENT;
                else if (r_op == OP_ADD && i_mem_rdata != NOT_QUEUED) begin
                    r_status <= ST_DUPLICATE;
                end else if (r_op == OP_REMOVE && i_mem_rdata == NOT_QUEUED) begin
                    r_status <= ST_ABSENT;
                end
            end
            S_AW1: r_x <= i_mem_rdata;
            S_UN: r_p <= i_mem_rdata;
            S_UW1: r_n <= i_mem_rdata;
            S_PW: begin
                if (i_mem_rdata != LINK_NULL) begin
                    r_popped <= i_mem_rdata[EW-1:0];
                    r_lv <= (EW+1)'(r_scan);
                    r_e <= i_mem_rdata[EW-1:0];
                end else if ((!r_order && r_scan == LW'(NUM_LEVELS - 1)) ||
                             (r_order && r_scan == '0)) begin
                    r_status <= ST_NO_POP;
                end else begin
                    r_scan <= r_order ? r_scan - 1'b1 : r_scan + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/core/mbpq_dp.sv =====
// link and level stores for the bucket priority queue
`timescale 1ns / 1ps
module mbpq_dp
    import mbpq_pkg::*;
(
    input  logic          i_clk,
    input  logic [2:0]    i_mem_sel,
    input  logic          i_mem_we,
    input  logic [EW-1:0] i_mem_addr,
    input  logic [EW:0]   i_mem_wdata,
    output logic [EW:0]   o_mem_rdata
);
    logic [EW:0]   w_head, w_tail, w_next, w_prev, w_lvl;
    logic [2:0]    r_sel;
    logic [LW-1:0] w_la;
    logic          w_clr, w_clr_lvl;
    logic          w_head_we, w_tail_we, w_lvl_we;
    logic [EW:0]   w_hl_wdata, w_lvl_wdata;

    assign w_la = i_mem_addr[LW-1:0];
    assign w_clr = i_mem_we && (i_mem_sel == MS_CLEAR);
    // the clearing pass empties every level while it walks the element range
    assign w_clr_lvl = w_clr && (i_mem_addr < EW'(NUM_LEVELS));
    assign w_head_we = (i_mem_we && i_mem_sel == MS_HEAD) || w_clr_lvl;
    assign w_tail_we = (i_mem_we && i_mem_sel == MS_TAIL) || w_clr_lvl;
    assign w_lvl_we = (i_mem_we && i_mem_sel == MS_LEVEL) || w_clr;
    assign w_hl_wdata = w_clr ? LINK_NULL : i_mem_wdata;
    assign w_lvl_wdata = w_clr ? NOT_QUEUED : i_mem_wdata;

    mbpq_ram #(.WIDTH(EW+1), .DEPTH(NUM_LEVELS)) u_head (
        .i_clk(i_clk), .i_we(w_head_we), .i_addr(w_la),
        .i_wdata(w_hl_wdata), .o_rdata(w_head));
    mbpq_ram #(.WIDTH(EW+1), .DEPTH(NUM_LEVELS)) u_tail (
        .i_clk(i_clk), .i_we(w_tail_we), .i_addr(w_la),
        .i_wdata(w_hl_wdata), .o_rdata(w_tail));
    mbpq_ram #(.WIDTH(EW+1), .DEPTH(NUM_ELEMENTS)) u_next (
        .i_clk(i_clk), .i_we(i_mem_we && i_mem_sel == MS_NEXT), .i_addr(i_mem_addr),
        .i_wdata(i_mem_wdata), .o_rdata(w_next));
    mbpq_ram #(.WIDTH(EW+1), .DEPTH(NUM_ELEMENTS)) u_prev (
        .i_clk(i_clk), .i_we(i_mem_we && i_mem_sel == MS_PREV), .i_addr(i_mem_addr),
        .i_wdata(i_mem_wdata), .o_rdata(w_prev));
    mbpq_ram #(.WIDTH(EW+1), .DEPTH(NUM_ELEMENTS)) u_lvl (
        .i_clk(i_clk), .i_we(w_lvl_we), .i_addr(i_mem_addr),
        .i_wdata(w_lvl_wdata), .o_rdata(w_lvl));

    always_ff @(posedge i_clk) begin
        r_sel <= i_mem_sel;
    end

    always_comb begin
        case (r_sel)
            MS_HEAD:  o_mem_rdata = w_head;
            MS_TAIL:  o_mem_rdata = w_tail;
            MS_NEXT:  o_mem_rdata = w_next;
            MS_PREV:  o_mem_rdata = w_prev;
            MS_LEVEL: o_mem_rdata = w_lvl;
            default:  o_mem_rdata = '0;
        endcase
    end
endmodule

// ===== rtl/core/monotone_bucket_priority_queue.sv =====
// top level of the monotone bucket priority queue
`timescale 1ns / 1ps
// Bucket priority queue over element ids with one linked list per priority
// level, kept in single-port RAMs behind one shared memory port. A pop scans
// the levels from the cursor and either unlinks the first head it finds or
// ends when nothing is left ahead of the cursor. After reset a clearing pass
// over the NUM_ELEMENTS element addresses empties every level and marks every
// element not queued before the first word is taken. One word is in flight at
// a time.
module monotone_bucket_priority_queue
    import mbpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_priority_req,
    input  logic [9:0]  i_element,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_popped_element,
    output logic        o_present,
    output logic        o_is_empty,
    output logic [10:0] o_count,
    output logic [1:0]  o_status
);
    logic [2:0]    w_sel;
    logic          w_we;
    logic [EW-1:0] w_addr;
    logic [EW:0]   w_wdata, w_rdata;

    mbpq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid, .o_ready,
        .i_op, .i_priority_req, .i_element, .o_valid, .i_ready, .o_popped_element,
        .o_present, .o_is_empty, .o_count, .o_status,
        .o_mem_sel(w_sel), .o_mem_we(w_we), .o_mem_addr(w_addr),
        .o_mem_wdata(w_wdata), .i_mem_rdata(w_rdata));

    mbpq_dp u_dp (
        .i_clk, .i_mem_sel(w_sel), .i_mem_we(w_we), .i_mem_addr(w_addr),
        .i_mem_wdata(w_wdata), .o_mem_rdata(w_rdata));
endmodule

// ===== tb/sv/monotone_bucket_priority_queue_test.sv =====
// self-checking testbench for the monotone bucket priority queue
`timescale 1ns / 1ps
module monotone_bucket_priority_queue_test
    import mbpq_pkg::*;
();

    localparam int LEVELS   = 256;
    localparam int ELEMENTS = 1024;
    localparam logic [10:0] NO_LINK   = 11'(ELEMENTS);
    localparam logic [8:0]  UNQUEUED  = 9'(LEVELS);
    localparam int DRAIN_CYCLES = 1200;
    localparam int RANDOM_PER_PHASE = 125;

    typedef struct packed {
        logic [9:0]  popped;
        logic        present;
        logic        empty;
        logic [10:0] count;
        logic [1:0]  status;
    } t_outcome;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] pri;
        logic [9:0] elem;
        logic       typed;
        t_outcome   want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = OP_QUERY;
    logic [7:0]  i_priority_req = 8'd0;
    logic [9:0]  i_element = 10'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_popped_element;
    logic        o_present;
    logic        o_is_empty;
    logic [10:0] o_count;
    logic [1:0]  o_status;

    monotone_bucket_priority_queue dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // queue image kept alongside the block
    logic [10:0] lvl_head [LEVELS];
    logic [10:0] lvl_tail [LEVELS];
    logic [10:0] nxt [ELEMENTS];
    logic [10:0] prv [ELEMENTS];
    logic [8:0]  lvl_of [ELEMENTS];
    logic [7:0]  scan_pos;
    logic [10:0] queued;
    logic        serve_max;
    logic        lifo;

    t_outcome pending_outcomes [$];
    int  mismatches = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  pops_served = 0;
    int  refusals = 0;
    bit  quiet = 1'b0;

    function automatic void detach(logic [9:0] e);
        logic [8:0]  lv;
        logic [10:0] p, n;
        lv = lvl_of[e];
        p = prv[e];
        n = nxt[e];
        if (p == NO_LINK) lvl_head[lv[7:0]] = n;
        else nxt[p[9:0]] = n;
        if (n == NO_LINK) lvl_tail[lv[7:0]] = p;
        else prv[n[9:0]] = p;
        lvl_of[e] = UNQUEUED;
        queued--;
    endfunction

    function automatic t_outcome serve_word(logic [1:0] op, logic [7:0] pri, logic [9:0] e);
        t_outcome r;
        int c;
        bit found;
        logic [10:0] t;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD: begin
                if (lvl_of[e] != UNQUEUED) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    if (!lifo) begin
                        t = lvl_tail[pri];
                        prv[e] = t;
                        nxt[e] = NO_LINK;
                        if (t == NO_LINK) lvl_head[pri] = {1'b0, e};
                        else nxt[t[9:0]] = {1'b0, e};
                        lvl_tail[pri] = {1'b0, e};
                    end else begin
                        t = lvl_head[pri];
                        nxt[e] = t;
                        prv[e] = NO_LINK;
                        if (t == NO_LINK) lvl_tail[pri] = {1'b0, e};
                        else prv[t[9:0]] = {1'b0, e};
                        lvl_head[pri] = {1'b0, e};
                    end
                    lvl_of[e] = {1'b0, pri};
                    queued++;
                end
            end
            OP_REMOVE: begin
                if (lvl_of[e] == UNQUEUED) r.status = ST_ABSENT;
                else detach(e);
            end
            OP_POP: begin
                c = scan_pos;
                found = 1'b0;
                forever begin
                    if (lvl_head[c] != NO_LINK) begin
                        found = 1'b1;
                        break;
                    end
                    if (!serve_max) begin
                        if (c >= LEVELS - 1) break;
                        c++;
                    end else begin
                        if (c == 0) break;
                        c--;
                    end
                end
                if (found) begin
                    scan_pos = 8'(c);
                    r.popped = lvl_head[c][9:0];
                    detach(r.popped);
                end else begin
                    r.status = ST_NO_POP;
                end
            end
            default: ;
        endcase
        r.present = (lvl_of[e] != UNQUEUED);
        r.empty = (queued == 0);
        r.count = queued;
        return r;
    endfunction

    // drive one word and hold it until the block takes it
    task automatic send_word(logic [1:0] op, logic [7:0] pri, logic [9:0] e,
                             bit typed, t_outcome want);
        t_outcome got;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_priority_req <= pri;
        i_element <= e;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        got = serve_word(op, pri, e);
        pending_outcomes.push_back(typed ? want : got);
        words_sent++;
        if (op == OP_POP && got.status == ST_OK) pops_served++;
        if (got.status != ST_OK) refusals++;
    endtask

    task automatic write_reg(logic idx, logic val);
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ORDER_MODE) begin
            serve_max = val;
            scan_pos = val ? 8'(LEVELS - 1) : 8'd0;
        end else begin
            lifo = val;
        end
    endtask

    function automatic t_outcome mk(logic [9:0] p, logic pr, logic [10:0] n, logic [1:0] s);
        t_outcome r;
        r.popped = p;
        r.present = pr;
        r.empty = (n == 0);
        r.count = n;
        r.status = s;
        return r;
    endfunction

    // result side: random back-pressure outside the quiet phase, and comparison
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                words_seen++;
                if (pending_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (want != {o_popped_element, o_present, o_is_empty, o_count, o_status})
                    begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t: exp pop=%0d pres=%0d empty=%0d cnt=%0d st=%0d",
                                $realtime, want.popped, want.present, want.empty,
                                want.count, want.status);
                            $display("    got pop=%0d pres=%0d empty=%0d cnt=%0d st=%0d",
                                o_popped_element, o_present, o_is_empty, o_count,
                                o_status);
                        end
                    end
                end
            end
            if (quiet) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 8);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    t_row directed [$];

    function automatic t_row rw(logic [1:0] op, logic [7:0] pri, logic [9:0] e,
                                logic typed, t_outcome want);
        t_row r;
        r.op = op;
        r.pri = pri;
        r.elem = e;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    task automatic random_phase(int n);
        logic [1:0] op;
        logic [7:0] pri;
        logic [9:0] e;
        int k, d;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            op = (k < 40) ? OP_ADD : (k < 60) ? OP_REMOVE : (k < 85) ? OP_POP : OP_QUERY;
            // small id pool so duplicates and removals hit queued elements
            e = ($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, ELEMENTS - 1))
                                            : 10'($urandom_range(0, 23));
            if ($urandom_range(0, 4) == 0) begin
                pri = 8'($urandom);
            end else begin
                d = $urandom_range(0, 7);
                if (!serve_max) begin
                    pri = (scan_pos + d > LEVELS - 1) ? 8'(LEVELS - 1) : scan_pos + 8'(d);
                end else begin
                    pri = (scan_pos < d) ? 8'd0 : scan_pos - 8'(d);
                end
            end
            send_word(op, pri, e, 1'b0, '0);
        end
    endtask

    initial begin
        for (int i = 0; i < LEVELS; i++) begin
            lvl_head[i] = NO_LINK;
            lvl_tail[i] = NO_LINK;
        end
        for (int i = 0; i < ELEMENTS; i++) begin
            nxt[i] = '0;
            prv[i] = '0;
            lvl_of[i] = UNQUEUED;
        end
        queued = '0;
        serve_max = 1'b0;
        lifo = 1'b0;
        scan_pos = '0;

        directed.push_back(rw(OP_QUERY,  8'd0,   10'd0,    1, mk(10'd0, 0, 11'd0, ST_OK)));
        directed.push_back(rw(OP_POP,    8'd0,   10'd0,    1, mk(10'd0, 0, 11'd0, ST_NO_POP)));
        directed.push_back(rw(OP_REMOVE, 8'd0,   10'd1023, 1, mk(10'd0, 0, 11'd0, ST_ABSENT)));
        directed.push_back(rw(OP_ADD,    8'd255, 10'd1023, 1, mk(10'd0, 1, 11'd1, ST_OK)));
        directed.push_back(rw(OP_ADD,    8'd0,   10'd1023, 1,
                              mk(10'd0, 1, 11'd1, ST_DUPLICATE)));
        directed.push_back(rw(OP_ADD,    8'd0,   10'd0,    1, mk(10'd0, 1, 11'd2, ST_OK)));
        directed.push_back(rw(OP_ADD,    8'd0,   10'd5,    0, '0));
        directed.push_back(rw(OP_ADD,    8'd7,   10'd682,  0, '0));
        directed.push_back(rw(OP_ADD,    8'd7,   10'd341,  0, '0));
        directed.push_back(rw(OP_ADD,    8'd7,   10'd100,  0, '0));
        directed.push_back(rw(OP_QUERY,  8'd170, 10'd341,  0, '0));
        directed.push_back(rw(OP_REMOVE, 8'd85,  10'd341,  0, '0));
        directed.push_back(rw(OP_REMOVE, 8'd0,   10'd341,  0, '0));
        directed.push_back(rw(OP_POP,    8'd0,   10'd0,    0, '0));
        directed.push_back(rw(OP_POP,    8'd0,   10'd5,    0, '0));
        directed.push_back(rw(OP_POP,    8'd0,   10'd100,  0, '0));
        directed.push_back(rw(OP_POP,    8'd0,   10'd0,    0, '0));
        directed.push_back(rw(OP_POP,    8'd0,   10'd0,    0, '0));
        // cursor now sits at the top: a lower add is stranded behind it
        directed.push_back(rw(OP_ADD,    8'd3,   10'd9,    0, '0));
        directed.push_back(rw(OP_POP,    8'd0,   10'd9,    0, '0));
        directed.push_back(rw(OP_QUERY,  8'd0,   10'd9,    0, '0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i])
            send_word(directed[i].op, directed[i].pri, directed[i].elem,
                      directed[i].typed, directed[i].want);

        write_reg(CFG_ORDER_MODE, 1'b1);
        write_reg(CFG_TIE_POLICY, 1'b1);
        random_phase(RANDOM_PER_PHASE);
        write_reg(CFG_ORDER_MODE, 1'b0);
        random_phase(RANDOM_PER_PHASE);
        write_reg(CFG_ORDER_MODE, 1'b1);
        write_reg(CFG_TIE_POLICY, 1'b0);
        random_phase(RANDOM_PER_PHASE);
        write_reg(CFG_ORDER_MODE, 1'b0);
        quiet = 1'b1;
        random_phase(RANDOM_PER_PHASE);

        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d words over four order/tie settings, %0d results checked",
                 words_sent, words_seen);
        $display("%0d successful pops, %0d error statuses, %0d mismatches",
                 pops_served, refusals, mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("monotone_bucket_priority_queue test passed");
        else
            $display("monotone_bucket_priority_queue test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("monotone_bucket_priority_queue test failed");
        $finish;
    end
endmodule

// ===== monotone_bucket_priority_queue.f =====
rtl/core/mbpq_pkg.sv
rtl/core/mbpq_ram.sv
rtl/core/mbpq_ctrl.sv
rtl/core/mbpq_dp.sv
rtl/core/monotone_bucket_priority_queue.sv
tb/sv/monotone_bucket_priority_queue_test.sv
